FILE: src/jesc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jesc_pkg;

	// Decoder state, one-hot
	typedef enum logic [4:0] {
		MODE_TEXT = 5'b00001,
		MODE_ESC  = 5'b00010,
		MODE_HEX1 = 5'b00100,
		MODE_SKIP = 5'b01000,
		MODE_HEX2 = 5'b10000
	} mode_t;

	// What the back end does with a queued command
	typedef enum logic [1:0] {
		K_BYTE = 2'd0,   // one raw data byte
		K_CP   = 2'd1,   // codepoint, UTF-8 encoded
		K_MARK = 2'd2    // bare end marker
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [20:0] cp;
		logic        last;
	} cmd_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;

	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] BMP_LOW_MAX = 16'hD7FF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] BMP_HIGH    = 16'hE000;
	localparam logic [15:0] LO_WRAP_ADD = 16'h2400;   // -DC00 mod 2^16
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	localparam logic [20:0] MAX_1B = 21'h00007F;
	localparam logic [20:0] MAX_2B = 21'h0007FF;
	localparam logic [20:0] MAX_3B = 21'h00FFFF;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	// {is_hex, value}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/jesc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jesc_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire jesc_pkg::cmd_t din,
	input  wire logic          pop,
	output jesc_pkg::cmd_t     dout,
	output logic               empty,
	output logic               full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jesc_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign dout  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: src/jesc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jesc_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic      in_last,
	input  wire logic      q_full,
	output logic           push,
	output jesc_pkg::cmd_t cmd
);

	jesc_pkg::mode_t mode_q, mode_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [15:0] acc_q, acc_d;
	logic        stop_q, stop_d;
	logic [9:0]  hsb_q, hsb_d;

	logic        accept, emit;
	logic [4:0]  hexv;
	logic [15:0] acc_feed, low_diff;
	logic        stop_feed, fourth;
	logic [20:0] pair_cp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign hexv      = jesc_pkg::hex_value(in_byte);
	assign acc_feed  = (!stop_q && hexv[4]) ? {acc_q[11:0], hexv[3:0]} : acc_q;
	assign stop_feed = stop_q | !hexv[4];
	assign fourth    = (dcnt_q == 2'd3);

	// Surrogate pair. A second unit below DC00 wraps in 32 bits and folds back
	// into a 16-bit value; only the low six high-surrogate bits survive there.
	assign low_diff = acc_feed - jesc_pkg::LO_SURR_MIN;
	always_comb begin
		if (acc_feed >= jesc_pkg::LO_SURR_MIN) begin
			pair_cp = ({1'b0, hsb_q, 10'd0} | {7'd0, low_diff[13:0]}) + jesc_pkg::SUPP_BASE;
		end else begin
			pair_cp = {5'd0, (acc_feed + jesc_pkg::LO_WRAP_ADD) | {hsb_q[5:0], 10'd0}};
		end
	end

	always_comb begin
		mode_d    = mode_q;
		dcnt_d    = dcnt_q;
		acc_d     = acc_q;
		stop_d    = stop_q;
		hsb_d     = hsb_q;
		emit      = 1'b0;
		cmd.kind  = jesc_pkg::K_BYTE;
		cmd.cp    = {13'd0, in_byte};
		cmd.last  = in_last;

		unique case (mode_q)
			jesc_pkg::MODE_ESC: begin
				mode_d = jesc_pkg::MODE_TEXT;
				emit   = 1'b1;
				unique case (in_byte)
					jesc_pkg::CH_U: begin
						mode_d = jesc_pkg::MODE_HEX1;
						dcnt_d = 2'd0;
						acc_d  = 16'd0;
						stop_d = 1'b0;
						emit   = 1'b0;
					end
					jesc_pkg::CH_N: cmd.cp = {13'd0, jesc_pkg::CTL_LF};
					jesc_pkg::CH_R: cmd.cp = {13'd0, jesc_pkg::CTL_CR};
					jesc_pkg::CH_T: cmd.cp = {13'd0, jesc_pkg::CTL_HT};
					jesc_pkg::CH_B: cmd.cp = {13'd0, jesc_pkg::CTL_BS};
					jesc_pkg::CH_F: cmd.cp = {13'd0, jesc_pkg::CTL_FF};
					default:        cmd.cp = {13'd0, in_byte};
				endcase
			end
			jesc_pkg::MODE_HEX1: begin
				acc_d  = acc_feed;
				stop_d = stop_feed;
				if (fourth) begin
					mode_d   = jesc_pkg::MODE_TEXT;
					cmd.kind = jesc_pkg::K_CP;
					cmd.cp   = {5'd0, acc_feed};
					emit     = 1'b1;
					priority if (acc_feed <= jesc_pkg::BMP_LOW_MAX) begin
						// plain BMP value
					end else if (acc_feed <= jesc_pkg::HI_SURR_MAX) begin
						hsb_d  = acc_feed[9:0];
						mode_d = jesc_pkg::MODE_SKIP;
						dcnt_d = 2'd0;
						emit   = 1'b0;
					end else if (acc_feed < jesc_pkg::BMP_HIGH) begin
						cmd.cp = 21'd0;   // lone low surrogate
					end else begin
						// above the surrogates: as is
					end
				end else begin
					dcnt_d = dcnt_q + 2'd1;
				end
			end
			jesc_pkg::MODE_SKIP: begin
				if (dcnt_q != 2'd0) begin
					mode_d = jesc_pkg::MODE_HEX2;
					dcnt_d = 2'd0;
					acc_d  = 16'd0;
					stop_d = 1'b0;
				end else begin
					dcnt_d = 2'd1;
				end
			end
			jesc_pkg::MODE_HEX2: begin
				acc_d  = acc_feed;
				stop_d = stop_feed;
				if (fourth) begin
					mode_d   = jesc_pkg::MODE_TEXT;
					cmd.kind = jesc_pkg::K_CP;
					cmd.cp   = pair_cp;
					emit     = 1'b1;
				end else begin
					dcnt_d = dcnt_q + 2'd1;
				end
			end
			default: begin
				mode_d = jesc_pkg::MODE_TEXT;
				if (in_byte == jesc_pkg::CH_BSLASH) begin
					mode_d = jesc_pkg::MODE_ESC;
				end else begin
					emit = 1'b1;
				end
			end
		endcase

		// end of string: always one command, state back to reset values
		if (in_last) begin
			if (!emit) begin
				cmd.kind = jesc_pkg::K_MARK;
				cmd.cp   = 21'd0;
			end
			emit   = 1'b1;
			mode_d = jesc_pkg::MODE_TEXT;
			dcnt_d = 2'd0;
			acc_d  = 16'd0;
			stop_d = 1'b0;
			hsb_d  = 10'd0;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jesc_pkg::MODE_TEXT;
			dcnt_q <= 2'd0;
			acc_q  <= 16'd0;
			stop_q <= 1'b0;
			hsb_q  <= 10'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			dcnt_q <= dcnt_d;
			acc_q  <= acc_d;
			stop_q <= stop_d;
			hsb_q  <= hsb_d;
		end
	end

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> push ##1 (mode_q == jesc_pkg::MODE_TEXT))
		else $error("last item did not close the string");

endmodule

`default_nettype wire

FILE: src/jesc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jesc_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire jesc_pkg::cmd_t head,
	input  wire logic       q_empty,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            out_last
);

	logic [3:0][7:0] bytes;
	logic [1:0]      n_m1;
	logic            bval;
	logic [1:0]      idx_q;
	logic            load, final_byte;
	logic            valid_q, bvalid_q, last_q;
	logic [7:0]      byte_q;

	// UTF-8 encode of a codepoint head command; a raw byte or a marker gives one byte
	always_comb begin
		bytes = '0;
		n_m1  = 2'd0;
		bval  = 1'b1;
		unique case (head.kind)
			jesc_pkg::K_MARK: begin
				bval = 1'b0;
			end
			jesc_pkg::K_CP: begin
				priority if (head.cp != 21'd0 && head.cp <= jesc_pkg::MAX_1B) begin
					bytes[0] = head.cp[7:0];
				end else if (head.cp <= jesc_pkg::MAX_2B) begin
					n_m1     = 2'd1;
					bytes[0] = jesc_pkg::LEAD2 | {3'd0, head.cp[10:6]};
					bytes[1] = jesc_pkg::CONT | {2'd0, head.cp[5:0]};
				end else if (head.cp <= jesc_pkg::MAX_3B) begin
					n_m1     = 2'd2;
					bytes[0] = jesc_pkg::LEAD3 | {4'd0, head.cp[15:12]};
					bytes[1] = jesc_pkg::CONT | {2'd0, head.cp[11:6]};
					bytes[2] = jesc_pkg::CONT | {2'd0, head.cp[5:0]};
				end else begin
					n_m1     = 2'd3;
					bytes[0] = jesc_pkg::LEAD4 | {5'd0, head.cp[20:18]};
					bytes[1] = jesc_pkg::CONT | {2'd0, head.cp[17:12]};
					bytes[2] = jesc_pkg::CONT | {2'd0, head.cp[11:6]};
					bytes[3] = jesc_pkg::CONT | {2'd0, head.cp[5:0]};
				end
			end
			default: begin
				bytes[0] = head.cp[7:0];
			end
		endcase
	end

	assign load       = !q_empty && (!valid_q || !out_stall);
	assign final_byte = (idx_q == n_m1);
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= bytes[idx_q];
			bvalid_q <= bval;
			last_q   <= head.last && final_byte;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign byte_valid = bvalid_q;
	assign out_last   = last_q;

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !bvalid_q) |-> (last_q && byte_q == 8'd0))
		else $error("end marker without last flag");

	a_midcmd_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !q_empty)
		else $error("partial command lost its queue entry");

endmodule

`default_nettype wire

FILE: src/json_escape_to_utf8_decoder.sv
// JSON string-body unescaper with UTF-16 to UTF-8 output.
// Input channel: one item per byte of the escaped string body (in_byte),
// in_last on the final byte. Accepted when in_valid is high and in_stall low.
// Output channel: one item per decoded UTF-8 byte (out_byte, byte_valid,
// out_last), accepted when out_valid is high and out_stall low.
// A front end runs the escape / hex / surrogate state machine and pushes one
// command per data-yielding or final input byte into a QUEUE_DEPTH-entry queue.
// A back end encodes each command and sends 1 to 4 bytes, one per cycle
// unless out_stall holds it. An accepted item passes through the queue and
// the output register before its first result byte is valid. Throughput:
// one item per cycle while each item yields at most one byte and out_stall
// stays low; a multi-byte codepoint holds the back end for each of its
// bytes, and in_stall rises only once the queue fills.
// A last byte that produces no data (or ends inside an escape) yields one
// item with byte_valid 0, out_byte 0 and out_last 1.
// Reset (arst_n low) empties the queue, drops out_valid and returns the
// decoder to plain text. While out_stall is high the output item holds and
// the queue keeps taking input until full.
`timescale 1ns / 1ps
`default_nettype none

module json_escape_to_utf8_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            out_last
);

	jesc_pkg::cmd_t push_cmd, head_cmd;
	logic           push, pop, q_empty, q_full;

	// classify and decode escapes
	jesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	// decouples decode from multi-byte output
	jesc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head_cmd),
		.empty  (q_empty),
		.full   (q_full)
	);

	// UTF-8 encode and serialize
	jesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.q_empty    (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire

FILE: verif/json_escape_to_utf8_decoder_tb.sv
`timescale 1ns / 1ps

module json_escape_to_utf8_decoder_tb;

	localparam int CLK_HALF     = 1;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 270;
	localparam int TAIL_CYCLES  = 16;       // quiet time after the last expected item
	localparam int LIMIT_CYCLES = 400000;   // far above the slowest legal run

	// one expected output item
	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last;
	} utf8_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	json_escape_to_utf8_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.out_last(out_last)
	);

	always #CLK_HALF clk = ~clk;

	int cycle_count = 0;
	int error_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ------------------------------------------------------------------
	// Decoder shadow: same state as the block, updated once per accepted
	// input item. Results of one item collect in step_bytes first, so the
	// end-of-string marking can be applied to the final one.
	// ------------------------------------------------------------------
	jesc_pkg::mode_t dec_mode;
	logic [1:0]  digit_cnt;
	logic [15:0] hex_acc;
	logic        hex_halted;
	logic [9:0]  high_bits;

	utf8_item_t  step_bytes[$];
	utf8_item_t  expected_utf8_q[$];

	function automatic void clear_decoder();
		dec_mode   = jesc_pkg::MODE_TEXT;
		digit_cnt  = 2'd0;
		hex_acc    = 16'h0000;
		hex_halted = 1'b0;
		high_bits  = 10'h000;
	endfunction

	// -1 for anything that is not an ASCII hex digit
	function automatic int nibble_of(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b) - int'("0");
		if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	// at most four bytes per input item; extras are dropped
	function automatic void emit(input logic [7:0] b, input logic v);
		utf8_item_t it;
		it.data  = b;
		it.valid = v;
		it.last  = 1'b0;
		if (step_bytes.size() < 4) step_bytes.push_back(it);
	endfunction

	// UTF-8 by range; zero takes the two-byte overlong form, above 10FFFF nothing
	function automatic void encode_cp(input logic [31:0] cp);
		if (cp <= 32'h7F && cp != 32'h0) begin
			emit(cp[7:0], 1'b1);
		end else if (cp <= 32'h7FF) begin
			emit({3'b110, cp[10:6]}, 1'b1);
			emit({2'b10, cp[5:0]}, 1'b1);
		end else if (cp <= 32'hFFFF) begin
			emit({4'b1110, cp[15:12]}, 1'b1);
			emit({2'b10, cp[11:6]}, 1'b1);
			emit({2'b10, cp[5:0]}, 1'b1);
		end else if (cp <= 32'h10FFFF) begin
			emit({5'b11110, cp[20:18]}, 1'b1);
			emit({2'b10, cp[17:12]}, 1'b1);
			emit({2'b10, cp[11:6]}, 1'b1);
			emit({2'b10, cp[5:0]}, 1'b1);
		end
	endfunction

	function automatic void open_unit();
		digit_cnt  = 2'd0;
		hex_acc    = 16'h0000;
		hex_halted = 1'b0;
	endfunction

	// one digit position; after the first non-hex byte the rest only count
	function automatic logic take_digit(input logic [7:0] b);
		int n;
		n = nibble_of(b);
		if (!hex_halted && n >= 0) hex_acc = {hex_acc[11:0], 4'(n)};
		else hex_halted = 1'b1;
		if (digit_cnt == 2'd3) return 1'b1;
		digit_cnt = digit_cnt + 2'd1;
		return 1'b0;
	endfunction

	function automatic void decode_input_byte(input logic [7:0] b, input logic lst);
		logic [31:0] cp;
		utf8_item_t  it;
		step_bytes.delete();
		case (dec_mode)
			jesc_pkg::MODE_ESC: begin
				dec_mode = jesc_pkg::MODE_TEXT;
				if (b == jesc_pkg::CH_U) begin
					dec_mode = jesc_pkg::MODE_HEX1;
					open_unit();
				end else if (b == jesc_pkg::CH_N) emit(jesc_pkg::CTL_LF, 1'b1);
				else if (b == jesc_pkg::CH_R) emit(jesc_pkg::CTL_CR, 1'b1);
				else if (b == jesc_pkg::CH_T) emit(jesc_pkg::CTL_HT, 1'b1);
				else if (b == jesc_pkg::CH_B) emit(jesc_pkg::CTL_BS, 1'b1);
				else if (b == jesc_pkg::CH_F) emit(jesc_pkg::CTL_FF, 1'b1);
				else emit(b, 1'b1);
			end
			jesc_pkg::MODE_HEX1: begin
				if (take_digit(b)) begin
					dec_mode = jesc_pkg::MODE_TEXT;
					if (hex_acc <= 16'hD7FF) begin
						encode_cp({16'h0, hex_acc});
					end else if (hex_acc <= 16'hDBFF) begin
						// high half of a pair: skip "\u", then the low half
						high_bits = hex_acc[9:0];
						dec_mode  = jesc_pkg::MODE_SKIP;
						digit_cnt = 2'd0;
					end else if (hex_acc < 16'hE000) begin
						encode_cp(32'h0);   // lone low half
					end else begin
						encode_cp({16'h0, hex_acc});
					end
				end
			end
			jesc_pkg::MODE_SKIP: begin
				if (digit_cnt >= 2'd1) begin
					dec_mode = jesc_pkg::MODE_HEX2;
					open_unit();
				end else begin
					digit_cnt = 2'd1;
				end
			end
			jesc_pkg::MODE_HEX2: begin
				if (take_digit(b)) begin
					// 32-bit wrap on purpose: a bad low half lands anywhere
					cp = ({22'h0, high_bits} << 10) | ({16'h0, hex_acc} - 32'hDC00);
					cp = cp + 32'h10000;
					encode_cp(cp);
					dec_mode = jesc_pkg::MODE_TEXT;
				end
			end
			default: begin
				dec_mode = jesc_pkg::MODE_TEXT;
				if (b == jesc_pkg::CH_BSLASH) dec_mode = jesc_pkg::MODE_ESC;
				else emit(b, 1'b1);
			end
		endcase
		if (lst) begin
			if (step_bytes.size() == 0) emit(8'h00, 1'b0);
			step_bytes[step_bytes.size() - 1].last = 1'b1;
			clear_decoder();
		end
		foreach (step_bytes[i]) begin
			it = step_bytes[i];
			expected_utf8_q.push_back(it);
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side: compare each accepted item with the oldest expectation,
	// then pick next cycle's stall. Stall density changes every stretch
	// (none, light, half, heavy) so some stretches run without back-pressure.
	// Values read here are the ones present at the edge: the block's outputs
	// and out_stall only move in the NBA region.
	// ------------------------------------------------------------------
	int stall_pct = 0;
	int stall_run = 0;

	always @(posedge clk) begin : out_monitor
		utf8_item_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_utf8_q.size() == 0) begin
				$error("unexpected item: out_byte %h byte_valid %b out_last %b",
					out_byte, byte_valid, out_last);
				error_count++;
			end else begin
				exp_item = expected_utf8_q.pop_front();
				if (out_byte !== exp_item.data) begin
					$error("out_byte: expected %h, got %h", exp_item.data, out_byte);
					error_count++;
				end
				if (byte_valid !== exp_item.valid) begin
					$error("byte_valid: expected %b, got %b", exp_item.valid, byte_valid);
					error_count++;
				end
				if (out_last !== exp_item.last) begin
					$error("out_last: expected %b, got %b", exp_item.last, out_last);
					error_count++;
				end
			end
		end
		if (stall_run == 0) begin
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			stall_run = $urandom_range(16, 160);
		end
		stall_run--;
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// ------------------------------------------------------------------
	// Input side. Items go out in bursts with random gaps; steady_flow turns
	// the gaps off for a whole string. Every call starts and ends on a
	// rising edge, and valid is never dropped and raised in the same step.
	// ------------------------------------------------------------------
	int   burst_left = 0;
	bit   steady_flow = 0;
	int   sent_items = 0;
	logic [7:0] text_q[$];

	task automatic send_item(input logic [7:0] b, input logic lst);
		int gap;
		if (!steady_flow && burst_left == 0) begin
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		do @(posedge clk); while (in_stall);
		decode_input_byte(b, lst);
		sent_items++;
	endtask

	// sends text_q as one string, in_last on its final byte
	task automatic send_text();
		foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// hold the input until every expected item has come out
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (expected_utf8_q.size() != 0) @(posedge clk);
	endtask

	function automatic void push_chars(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	// hex digit of either case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0") + 8'(n);
		return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (nibble_of(c) >= 0);
		return c;
	endfunction

	// "\u" and four digits; a broken unit gets one digit replaced
	function automatic void push_unit(input logic [15:0] v, input bit broken);
		int bad_pos;
		bad_pos = broken ? $urandom_range(3) : 4;
		push_chars("\\u");
		for (int i = 3; i >= 0; i--) begin
			if (3 - i == bad_pos) text_q.push_back(non_hex_char());
			else text_q.push_back(hex_char(v[i*4 +: 4]));
		end
	endfunction

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(6))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hD7FF));
			3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
			4: return 16'($urandom_range(16'hE000, 16'hFFFF));
			5: return 16'($urandom_range(16'hD800, 16'hDBFF));
			default: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	function automatic void push_pair();
		logic [15:0] hi;
		logic [15:0] lo;
		hi = 16'($urandom_range(16'hD800, 16'hDBFF));
		lo = 16'($urandom_range(16'hDC00, 16'hDFFF));
		push_unit(hi, $urandom_range(9) == 0);
		// the two skipped bytes are not checked by the block
		if ($urandom_range(7) == 0) begin
			text_q.push_back(8'($urandom_range(255)));
			text_q.push_back(8'($urandom_range(255)));
		end else begin
			push_chars("\\u");
		end
		text_q.push_back(hex_char(lo[15:12]));
		text_q.push_back(hex_char(lo[11:8]));
		text_q.push_back(hex_char(lo[7:4]));
		text_q.push_back(hex_char(lo[3:0]));
		// bad low half now and then
		if ($urandom_range(5) == 0) begin
			repeat (4) text_q.pop_back();
			lo = 16'($urandom);
			for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(lo[i*4 +: 4]));
		end
	endfunction

	function automatic void push_escape();
		case ($urandom_range(6))
			0: push_chars("\\n");
			1: push_chars("\\r");
			2: push_chars("\\t");
			3: push_chars("\\b");
			4: push_chars("\\f");
			default: begin
				text_q.push_back(jesc_pkg::CH_BSLASH);
				text_q.push_back(8'($urandom_range(255)));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// raw zero, both byte extremes, last flag on a plain data byte
	task automatic test_raw_bytes();
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		push_chars("A");
		send_text();
	endtask

	// every control escape plus a pass-through escape
	task automatic test_simple_escapes();
		push_chars("\\n\\r\\t\\b\\f\\\"");
		send_text();
	endtask

	// short hex run cut by a non-hex digit, top of BMP, lone low half
	task automatic test_hex_units();
		push_chars("\\u7Gzz");
		push_chars("\\uFFFF");
		push_chars("\\uDFFF");
		send_text();
	endtask

	// largest supplementary codepoint: four bytes from one item
	task automatic test_surrogate_pair();
		push_chars("\\uDBFF\\uDFFF");
		send_text();
	endtask

	// string ends inside a hex unit, then right after a backslash
	task automatic test_early_end();
		push_chars("\\u12");
		send_text();
		text_q.push_back(jesc_pkg::CH_BSLASH);
		send_text();
	endtask

	// random strings, mostly well-formed escapes with random content
	task automatic test_random_strings();
		int  n_tokens;
		int  start_count;
		bit  paused;
		logic [7:0] plain;
		start_count = sent_items;
		paused = 0;
		while (sent_items - start_count < RANDOM_ITEMS) begin
			n_tokens = $urandom_range(1, 8);
			repeat (n_tokens) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4: begin
						do plain = 8'($urandom_range(8'h20, 8'h7E));
						while (plain == jesc_pkg::CH_BSLASH);
						text_q.push_back(plain);
					end
					5, 6: text_q.push_back(8'($urandom_range(255)));
					7, 8, 9, 10: push_escape();
					11, 12, 13, 14: push_unit(pick_unit(), $urandom_range(6) == 0);
					default: push_pair();
				endcase
			end
			// cut some strings short so they end inside an escape
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 5)) if (text_q.size() > 1) void'(text_q.pop_back());
			end
			steady_flow = ($urandom_range(3) == 0);
			send_text();
			steady_flow = 0;
			if (!paused && sent_items - start_count >= RANDOM_ITEMS / 2) begin
				drain_outputs();
				paused = 1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		clear_decoder();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_bytes();
		test_simple_escapes();
		test_hex_units();
		test_surrogate_pair();
		test_early_end();
		test_random_strings();

		in_valid <= 1'b0;
		while (expected_utf8_q.size() != 0) @(posedge clk);
		// catch anything extra coming out late
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("FAIL");
		$finish;
	end

endmodule
